FILE: rtl/core/apdu_pkg.sv
// shared types and codes for the apdu frame reassembler
// no dependencies; imported by apdu_parse, apdu_skid and the top level
package apdu_pkg;

    // input beat op codes
    localparam logic [1:0] OP_INIT_FIRST = 2'd0;
    localparam logic [1:0] OP_INIT_NEXT  = 2'd1;
    localparam logic [1:0] OP_CONT_FIRST = 2'd2;
    localparam logic [1:0] OP_CONT_NEXT  = 2'd3;

    // byte role codes
    localparam logic [1:0] ROLE_HEADER = 2'd0;
    localparam logic [1:0] ROLE_LENGTH = 2'd1;
    localparam logic [1:0] ROLE_DATA   = 2'd2;
    localparam logic [1:0] ROLE_DROP   = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_LE   = 2'd1;
    localparam logic [1:0] STAT_SHORT    = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW = 2'd3;

    // data count width and saturation point
    localparam int unsigned CNT_W = 20;
    localparam logic [CNT_W-1:0] COUNT_MAX = 20'hFFFFF;

    // Le encodings for a zero short or extended length field
    localparam logic [16:0] LE_SHORT_ZERO = 17'd256;
    localparam logic [16:0] LE_EXT_ZERO   = 17'h10000;

    localparam int unsigned DEPTH_DEFAULT = 1024;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic       frame_last;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  byte_role;
        logic [9:0]  data_addr;
        logic        frame_done;
        logic [7:0]  cla;
        logic [7:0]  ins;
        logic [7:0]  p1;
        logic [7:0]  p2;
        logic [15:0] lc;
        logic [16:0] le;
        logic [10:0] data_count;
        logic [1:0]  status;
    } t_out_beat;

endpackage

FILE: rtl/core/apdu_parse.sv
// per-byte apdu phase machine: header capture, Lc/Le decode, data addressing
// depends on apdu_pkg
module apdu_parse #(
    parameter int unsigned DEPTH = apdu_pkg::DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  apdu_pkg::t_in_beat  i_beat,
    output apdu_pkg::t_out_beat o_result
);
    import apdu_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN1,
        PH_LENHI,
        PH_LENLO,
        PH_DATA
    } t_phase;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    t_phase            r_phase, n_phase, c_phase;
    logic [1:0]        r_pos, n_pos, c_pos;
    logic [3:0][7:0]   r_hdr, n_hdr, c_hdr;
    logic [15:0]       r_lc, n_lc, c_lc;
    logic [16:0]       r_le, n_le, c_le;
    logic [CNT_W-1:0]  r_count, n_count, c_count;
    logic [15:0]       r_last2, n_last2, c_last2;
    logic              r_ovf, n_ovf, c_ovf;

    logic              new_apdu;
    logic [15:0]       shifted;
    logic [CNT_W-1:0]  inc_count;
    logic [CNT_W-1:0]  extra;
    logic [CNT_W-1:0]  stored;
    logic [1:0]        role;
    logic [9:0]        addr;
    logic [1:0]        status;

    // an init-frame first byte starts from cleared state
    assign new_apdu = (i_beat.op == OP_INIT_FIRST);

    always_comb begin
        if (new_apdu) begin
            c_phase = PH_HEADER;
            c_pos   = '0;
            c_hdr   = '0;
            c_lc    = '0;
            c_le    = '0;
            c_count = '0;
            c_last2 = '0;
            c_ovf   = 1'b0;
        end else begin
            c_phase = r_phase;
            c_pos   = r_pos;
            c_hdr   = r_hdr;
            c_lc    = r_lc;
            c_le    = r_le;
            c_count = r_count;
            c_last2 = r_last2;
            c_ovf   = r_ovf;
        end
    end

    assign shifted   = {c_last2[7:0], i_beat.data_byte};
    assign inc_count = (c_count < COUNT_MAX) ? c_count + 1'b1 : c_count;
    assign extra     = inc_count - {4'b0, c_lc};

    // byte machine
    always_comb begin
        n_phase = c_phase;
        n_pos   = c_pos;
        n_hdr   = c_hdr;
        n_lc    = c_lc;
        n_le    = c_le;
        n_count = c_count;
        n_last2 = c_last2;
        n_ovf   = c_ovf;
        role    = ROLE_HEADER;
        addr    = '0;
        status  = STAT_OK;

        unique case (c_phase)
            PH_HEADER: begin
                role = ROLE_HEADER;
                n_hdr[c_pos] = i_beat.data_byte;
                if (c_pos == 2'd3) begin
                    n_phase = PH_LEN1;
                    n_pos   = '0;
                end else begin
                    n_pos = c_pos + 1'b1;
                    if (i_beat.frame_last) status = STAT_SHORT;
                end
            end
            PH_LEN1: begin
                role    = ROLE_LENGTH;
                n_last2 = shifted;
                if (i_beat.data_byte != 8'd0) begin
                    if (i_beat.frame_last) begin
                        n_lc = '0;
                        n_le = {9'd0, i_beat.data_byte};
                    end else begin
                        n_lc = {8'd0, i_beat.data_byte};
                    end
                    n_phase = PH_DATA;
                end else if (i_beat.frame_last) begin
                    n_lc    = '0;
                    n_le    = LE_SHORT_ZERO;
                    n_phase = PH_DATA;
                end else begin
                    n_phase = PH_LENHI;
                end
            end
            PH_LENHI: begin
                role    = ROLE_LENGTH;
                n_last2 = shifted;
                if (i_beat.frame_last) status = STAT_SHORT;
                n_phase = PH_LENLO;
            end
            PH_LENLO: begin
                role    = ROLE_LENGTH;
                n_last2 = shifted;
                if (i_beat.frame_last) begin
                    n_lc = '0;
                    n_le = (shifted != 16'd0) ? {1'b0, shifted} : LE_EXT_ZERO;
                end else begin
                    n_lc = shifted;
                end
                n_phase = PH_DATA;
            end
            PH_DATA: begin
                n_last2 = shifted;
                if (c_count < DEPTH_CNT) begin
                    role = ROLE_DATA;
                    addr = c_count[9:0];
                end else begin
                    role  = ROLE_DROP;
                    n_ovf = 1'b1;
                end
                n_count = inc_count;
                // bytes beyond Lc at frame end: one or two of them are Le
                if (i_beat.frame_last && (inc_count > {4'b0, c_lc})) begin
                    if (extra == CNT_W'(1)) begin
                        n_le = (shifted[7:0] != 8'd0) ? {9'd0, shifted[7:0]}
                                                      : LE_SHORT_ZERO;
                        n_count = inc_count - CNT_W'(1);
                    end else if (extra == CNT_W'(2)) begin
                        n_le = (shifted != 16'd0) ? {1'b0, shifted} : LE_EXT_ZERO;
                        n_count = inc_count - CNT_W'(2);
                    end else begin
                        status = STAT_BAD_LE;
                    end
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        if (n_ovf) status = STAT_OVERFLOW;
    end

    assign stored = (n_count < DEPTH_CNT) ? n_count : DEPTH_CNT;

    // result of the current beat
    always_comb begin
        o_result.byte_role  = role;
        o_result.data_addr  = addr;
        o_result.frame_done = i_beat.frame_last;
        o_result.cla        = n_hdr[0];
        o_result.ins        = n_hdr[1];
        o_result.p1         = n_hdr[2];
        o_result.p2         = n_hdr[3];
        o_result.lc         = n_lc;
        o_result.le         = n_le;
        o_result.data_count = stored[10:0];
        o_result.status     = status;
    end

    // state update on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_hdr   <= '0;
            r_lc    <= '0;
            r_le    <= '0;
            r_count <= '0;
            r_last2 <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_hdr   <= n_hdr;
            r_lc    <= n_lc;
            r_le    <= n_le;
            r_count <= n_count;
            r_last2 <= n_last2;
            r_ovf   <= n_ovf;
        end
    end

    // data count only moves once the length field is done
    a_count_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) || (r_count == '0))
        else $error("data count nonzero outside data phase");

    // header position only advances in the header phase
    a_pos_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == 2'd0) || (r_phase == PH_HEADER))
        else $error("header position set outside header phase");

    // a new apdu leaves one header byte captured
    a_new_apdu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && new_apdu) |=> (r_phase == PH_HEADER) && (r_pos == 2'd1))
        else $error("new apdu did not restart the header");

    // overflow flag implies the count reached the buffer depth at some point
    a_ovf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count + CNT_W'(2) > DEPTH_CNT))
        else $error("overflow flagged below buffer depth");

endmodule

FILE: rtl/core/apdu_skid.sv
// output register with one skid entry; decouples downstream stall from input
// depends on apdu_pkg
module apdu_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  apdu_pkg::t_out_beat i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output apdu_pkg::t_out_beat o_data
);
    import apdu_pkg::*;

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_beat r_out;
    t_out_beat r_skid;
    logic      accept;
    logic      out_free;

    assign o_stall  = r_skid_valid;
    assign accept   = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= i_data;
            end
        end else if (accept) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // skid entry only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // a waiting skid beat moves up when the output is taken
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid beat not moved to output");

endmodule

FILE: rtl/core/apdu_frame_reassembler.sv
// top level of the apdu frame reassembler
// depends on apdu_pkg, apdu_parse and apdu_skid
//
// Takes a command apdu one byte per beat on the input channel (op, data_byte,
// frame_last) and returns exactly one result beat per input beat: the role of
// the byte, its store address when it is a data byte, and the running summary
// (CLA, INS, P1, P2, Lc, Le, stored data count, status).
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// The result of a byte is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one byte per cycle while the output is not stalled; the byte machine decodes a byte in a single
// pass between the parse state registers and the output register.
// Reset clears the phase machine, captured header, Lc, Le and counts, and
// empties the output stage. An init-frame first byte also clears all state.
// When the receiver stalls, the output beat holds, one more byte is taken
// into a skid entry, and then o_in_stall rises until the output drains.
// Data beyond DEPTH bytes is marked dropped and status reports overflow.
module apdu_frame_reassembler #(
    parameter int unsigned DEPTH = apdu_pkg::DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  apdu_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output apdu_pkg::t_out_beat o_out_beat
);
    import apdu_pkg::*;

    t_out_beat result;
    logic      in_accept;

    assign in_accept = i_in_valid && !o_in_stall;

    // byte machine
    apdu_parse #(
        .DEPTH (DEPTH)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_beat   (i_in_beat),
        .o_result (result)
    );

    // output register and skid entry
    apdu_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (result),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_beat)
    );

endmodule
